// ===== rtl/i2c_master_byte_engine_unit_macros.svh =====
// Assertion helpers shared by the RTL of the I2C byte engine.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define I2CMBE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define I2CMBE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define I2CMBE_ASSERT_SAME(label, clk, rstn, ante, cons)

`define I2CMBE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // Last phase index of each command, and the ACK and final-bit phases of a byte transfer.
    localparam logic [4:0] START_LAST_PHASE = 5'd3;
    localparam logic [4:0] STOP_LAST_PHASE  = 5'd2;
    localparam logic [4:0] BYTE_LAST_PHASE  = 5'd18;
    localparam logic [4:0] BYTE_ACK_LOW     = 5'd16;
    localparam logic [4:0] BYTE_ACK_HIGH    = 5'd17;
    localparam logic [4:0] BYTE_FINAL_BIT   = 5'd15;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } out_t;

endpackage

// ===== rtl/i2c_master_byte_engine_unit.sv =====
// A result is registered and presented on m_data in the cycle after its tick is transferred in.
// Throughput: one tick per cycle while m_ready is high; a tick may be taken while the previous result is being
// taken, since the output register frees itself on the same edge.
// Reset (aresetn low, synchronous): bus idle with SCL and SDA released, no result pending,
// received byte and missing-ACK flag cleared.
`include "i2c_master_byte_engine_unit_macros.svh"

module i2c_master_byte_engine_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  i2cmbe_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output i2cmbe_pkg::out_t m_data
);

    i2cmbe_pkg::cmd_t cmd_reg, cmd_next;
    logic [4:0]       phase_reg, phase_next;
    logic [7:0]       shift_reg, shift_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             nack_seen_reg, nack_seen_next;
    logic             ack_choice_reg, ack_choice_next;
    logic [7:0]       rx_hold_reg, rx_hold_next;
    logic             m_valid_reg;
    i2cmbe_pkg::out_t m_data_reg, m_data_next;

    i2cmbe_pkg::cmd_t cmd_eff;
    logic [4:0]       phase_eff;
    logic [7:0]       shift_eff;
    logic             ack_eff;
    logic             last;
    logic             mode_ok;
    logic             take;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign mode_ok = (s_data.mode == i2cmbe_pkg::CMD_START)
                  || (s_data.mode == i2cmbe_pkg::CMD_STOP)
                  || (s_data.mode == i2cmbe_pkg::CMD_WRITE)
                  || (s_data.mode == i2cmbe_pkg::CMD_READ);

    always_comb begin
        cmd_eff         = cmd_reg;
        phase_eff       = phase_reg;
        shift_eff       = shift_reg;
        ack_eff         = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        shift_next      = shift_reg;
        nack_seen_next  = nack_seen_reg;
        rx_hold_next    = rx_hold_reg;
        last            = 1'b0;

        // A new command is latched only while the engine is idle.
        if (cmd_reg == i2cmbe_pkg::CMD_NONE && mode_ok) begin
            cmd_eff   = i2cmbe_pkg::cmd_t'(s_data.mode);
            phase_eff = '0;
            if (s_data.mode == i2cmbe_pkg::CMD_WRITE) begin
                shift_eff = s_data.tx_byte;
            end else if (s_data.mode == i2cmbe_pkg::CMD_READ) begin
                shift_eff = '0;
                ack_eff   = s_data.send_nack;
            end
        end
        shift_next      = shift_eff;
        ack_choice_next = ack_eff;

        case (cmd_eff)
            i2cmbe_pkg::CMD_START: begin
                if (phase_eff == 5'd0) begin
                    sda_next = 1'b1;
                end else if (phase_eff == 5'd1) begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end else if (phase_eff == 5'd2) begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end else begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                    last     = 1'b1;
                end
            end
            i2cmbe_pkg::CMD_STOP: begin
                if (phase_eff == 5'd0) begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end else if (phase_eff == 5'd1) begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                end else begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    last     = 1'b1;
                end
            end
            i2cmbe_pkg::CMD_WRITE: begin
                if (phase_eff < i2cmbe_pkg::BYTE_ACK_LOW) begin
                    sda_next = shift_eff[7];
                    scl_next = phase_eff[0];
                    if (phase_eff[0]) begin
                        shift_next = {shift_eff[6:0], 1'b0};
                    end
                end else if (phase_eff == i2cmbe_pkg::BYTE_ACK_LOW) begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end else if (phase_eff == i2cmbe_pkg::BYTE_ACK_HIGH) begin
                    scl_next       = 1'b1;
                    sda_next       = 1'b1;
                    nack_seen_next = s_data.sda_in;
                end else begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    last     = 1'b1;
                end
            end
            i2cmbe_pkg::CMD_READ: begin
                if (phase_eff < i2cmbe_pkg::BYTE_ACK_LOW) begin
                    sda_next = 1'b1;
                    scl_next = phase_eff[0];
                    if (phase_eff[0]) begin
                        shift_next = {shift_eff[6:0], s_data.sda_in};
                        if (phase_eff == i2cmbe_pkg::BYTE_FINAL_BIT) begin
                            rx_hold_next = {shift_eff[6:0], s_data.sda_in};
                        end
                    end
                end else if (phase_eff == i2cmbe_pkg::BYTE_ACK_LOW) begin
                    scl_next = 1'b0;
                    sda_next = ack_eff;
                end else if (phase_eff == i2cmbe_pkg::BYTE_ACK_HIGH) begin
                    scl_next = 1'b1;
                    sda_next = ack_eff;
                end else begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    last     = 1'b1;
                end
            end
            default: begin
            end
        endcase

        cmd_next   = cmd_eff;
        phase_next = phase_eff;
        if (cmd_eff != i2cmbe_pkg::CMD_NONE) begin
            if (last) begin
                cmd_next   = i2cmbe_pkg::CMD_NONE;
                phase_next = '0;
            end else begin
                phase_next = 5'(phase_eff + 5'd1);
            end
        end

        m_data_next.scl         = scl_next;
        m_data_next.sda_out     = sda_next;
        m_data_next.busy_res    = (cmd_next != i2cmbe_pkg::CMD_NONE);
        m_data_next.done_res    = last;
        m_data_next.rx_byte     = rx_hold_next;
        m_data_next.ack_missing = nack_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= i2cmbe_pkg::CMD_NONE;
            phase_reg      <= '0;
            shift_reg      <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            nack_seen_reg  <= 1'b0;
            ack_choice_reg <= 1'b0;
            rx_hold_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (take) begin
                cmd_reg        <= cmd_next;
                phase_reg      <= phase_next;
                shift_reg      <= shift_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                nack_seen_reg  <= nack_seen_next;
                ack_choice_reg <= ack_choice_next;
                rx_hold_reg    <= rx_hold_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= m_data_next;
        end
    end

    // A completing result never also claims the engine is still busy.
    `I2CMBE_ASSERT_SAME(a_done_not_busy, aclk, aresetn, m_valid_reg && m_data_reg.done_res, !m_data_reg.busy_res)
    // The phase counter sits at zero whenever no command is held.
    `I2CMBE_ASSERT_SAME(a_idle_phase_zero, aclk, aresetn, cmd_reg == i2cmbe_pkg::CMD_NONE, phase_reg == 5'd0)
    // No command runs beyond the final phase of a byte transfer.
    `I2CMBE_ASSERT_SAME(a_phase_bound, aclk, aresetn, 1'b1, phase_reg <= i2cmbe_pkg::BYTE_LAST_PHASE)
    // A held command that does not finish advances exactly one phase per transfer.
    `I2CMBE_ASSERT_NEXT(a_phase_step, aclk, aresetn, take && cmd_reg != i2cmbe_pkg::CMD_NONE && !last, phase_reg == 5'($past(phase_reg) + 5'd1))

endmodule
